[rtl/bdq_pkg.sv]
// Shared types and constants of the byte deque with search.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int OP_W        = 3;
  localparam int DATA_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 6;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   byte_t;

  localparam op_t OP_INS_FRONT = 3'd0;
  localparam op_t OP_INS_BACK  = 3'd1;
  localparam op_t OP_DEL_FRONT = 3'd2;
  localparam op_t OP_DEL_BACK  = 3'd3;
  localparam op_t OP_TRAVERSE  = 3'd4;
  localparam op_t OP_SEARCH    = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

[rtl/byte_deque_with_search_core.sv]
// Top level of the byte deque with front and back insert, delete, traverse and search.
`timescale 1ns / 1ps

// A request is taken in one cycle and executed in the next. Inserts, deletes, empty-store
// answers and unknown operation codes give one transfer. A traverse gives one transfer
// per stored byte and a search inspects one byte per entry; both read each entry
// through the single registered read port of the store and the one shared ring adder,
// check it in the check state and pass a read state between entries. Stalls on the
// result side hold the flow. The final transfer of every request carries tlast.
module byte_deque_with_search_core #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation [2:0], data_byte [10:3], zero [15:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status [1:0], item_value [9:2], position [15:10],
                                  // entry_count [22:16], zero [23]
  output logic        out_tlast
);

  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_RD   = 4'b0100,
    S_CHK  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  bdq_pkg::op_t         op_r, op_nxt;
  bdq_pkg::byte_t       key_r, key_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  bdq_pkg::status_t     out_status_r, out_status_nxt;
  bdq_pkg::byte_t       out_value_r, out_value_nxt;
  logic [bdq_pkg::POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [bdq_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 full;
  logic                 empty;
  logic                 at_last;
  logic [IDX_W-1:0]     ring_off;
  logic [IDX_W-1:0]     ring_addr;
  logic                 ram_we;
  bdq_pkg::byte_t       rd_data;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign at_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    ring_off = idx_r;
    if (state_r == S_EXEC) begin
      case (op_r)
        bdq_pkg::OP_INS_FRONT: ring_off = IDX_W'(CAPACITY - 1);
        bdq_pkg::OP_INS_BACK:  ring_off = count_r[IDX_W-1:0];
        bdq_pkg::OP_DEL_FRONT: ring_off = IDX_W'(1);
        default:               ring_off = idx_r;
      endcase
    end
  end

  bdq_ring_add #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_ring_add (
    .base   (head_r),
    .offset (ring_off),
    .result (ring_addr)
  );

  bdq_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ring_addr),
    .wdata (key_r),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tdata[2:0];
          key_nxt   = in_tdata[10:3];
          idx_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((op_r == bdq_pkg::OP_TRAVERSE || op_r == bdq_pkg::OP_SEARCH) && !empty) begin
          state_nxt = S_CHK;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bdq_pkg::ST_OK;
          out_value_nxt  = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          case (op_r)
            bdq_pkg::OP_INS_FRONT, bdq_pkg::OP_INS_BACK: begin
              if (full) begin
                out_status_nxt = bdq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (op_r == bdq_pkg::OP_INS_FRONT) begin
                  head_nxt = ring_addr;
                end
              end
            end
            bdq_pkg::OP_DEL_FRONT, bdq_pkg::OP_DEL_BACK: begin
              if (empty) begin
                out_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (op_r == bdq_pkg::OP_DEL_FRONT) begin
                  head_nxt = ring_addr;
                end
              end
            end
            bdq_pkg::OP_TRAVERSE, bdq_pkg::OP_SEARCH: begin
              out_status_nxt = bdq_pkg::ST_EMPTY;
            end
            default: begin
              out_status_nxt = bdq_pkg::ST_OK;
            end
          endcase
          out_count_nxt = bdq_pkg::COUNT_W'(count_nxt);
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (op_r == bdq_pkg::OP_TRAVERSE) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bdq_pkg::ST_OK;
            out_value_nxt  = rd_data;
            out_pos_nxt    = bdq_pkg::POS_W'(idx_r);
            out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
            out_last_nxt   = at_last;
            if (at_last) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = S_RD;
            end
          end
        end else if (rd_data == key_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bdq_pkg::ST_OK;
            out_value_nxt  = rd_data;
            out_pos_nxt    = bdq_pkg::POS_W'(idx_r);
            out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (at_last) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bdq_pkg::ST_NOT_FOUND;
            out_value_nxt  = '0;
            out_pos_nxt    = '0;
            out_count_nxt  = bdq_pkg::COUNT_W'(count_r);
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_pos_r, out_value_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (IDX_W+1)'(CAPACITY))
    else $error("Head index lies outside the ring.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("A new request was offered a transfer while one is executing.");

  a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !full && state_r == S_EXEC)
    else $error("The store was written while full or outside execution.");
`endif

endmodule

[rtl/bdq_ram.sv]
// Element store of the deque: one write port and one registered read port.
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       addr,
  input  bdq_pkg::byte_t      wdata,
  output bdq_pkg::byte_t      rdata
);

  bdq_pkg::byte_t mem [DEPTH];
  bdq_pkg::byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/bdq_ring_add.sv]
// Shared ring index adder: base plus offset, wrapped at the capacity.
`timescale 1ns / 1ps

module bdq_ring_add #(
  parameter int CAPACITY = 32,
  parameter int IDX_W    = 5
) (
  input  logic [IDX_W-1:0] base,
  input  logic [IDX_W-1:0] offset,
  output logic [IDX_W-1:0] result
);

  logic [IDX_W:0] sum;

  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    result = sum[IDX_W-1:0];
  end

endmodule
